// ----- hdl/acnvs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acnvs_pkg
// Shared constants and types of the next-vertex selector.
// ----------------------------------------------------------------------------
package acnvs_pkg;

  localparam int MaxVertices = 16;
  localparam int VCount = (MaxVertices > 16) ? 16 : MaxVertices;
  localparam int VtxW = 4;
  localparam int AddrW = 2 * VtxW;
  localparam int WeightW = 32;
  localparam int TotalW = WeightW + VtxW;
  localparam int RunW = TotalW + 7;
  localparam logic [6:0] Percent = 7'd100;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [15:0] pheromone;
    logic [15:0] distance;
  } edge_t;

endpackage
`default_nettype wire

// ----- hdl/ant_colony_next_vertex_select_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ant_colony_next_vertex_select_unit
// Roulette-wheel choice of the next vertex of an ant tour over an edge memory.
// ----------------------------------------------------------------------------
// Items are handled one at a time, and in_tready is high only in the idle
// state. A write stores one direction of the edge in the transfer cycle and
// the other direction in the next cycle. A step walks the 16 vertices up to
// twice. Each candidate is selected in S_NEXT, read from memory in S_RD and
// weighted in S_DIV by a restoring divider for pheromone * 65536 / distance,
// which gives a zero weight for a zero distance without dividing. Other
// vertices are skipped in S_NEXT. The first pass sums the weights and the
// second stops at the chosen vertex. The result register parts the two
// sides: writes and starts are taken while a result waits, and a finished
// step holds until the register is free.
module ant_colony_next_vertex_select_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // command[1:0], vertex_a[5:2], vertex_b[9:6], distance[25:10],
  // pheromone[41:26], random_value[48:42], zeros[55:49]
  input  wire  [55:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // next_vertex[3:0], zeros[7:4]
  output logic [7:0]  out_tdata,
  // no_choice[0]
  output logic        out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE, S_WR2, S_RD, S_DIV, S_NEXT, S_RESULT
  } state_t;

  localparam int VW = acnvs_pkg::VtxW;
  localparam int WW = acnvs_pkg::WeightW;

  acnvs_pkg::edge_t mem [0:255];
  acnvs_pkg::edge_t rd_q;

  state_t state_r;
  logic [15:0] mask_r;
  logic [VW-1:0] cur_r, vtx_r, b_r, pick_r;
  logic pass_r;
  logic none_r;
  logic [6:0] rnd_r;
  logic [15:0] dist_r, pher_r;
  logic [acnvs_pkg::TotalW-1:0] total_r, run_r;
  logic [47:0] quo_r;
  logic [16:0] rem_r;
  logic [5:0] cnt_r;
  logic wr_en;
  logic wr_ok;
  logic [acnvs_pkg::AddrW-1:0] wr_addr, rd_addr;
  logic [acnvs_pkg::RunW-1:0] lhs, rhs;
  logic [15:0] all_mask, cand;
  logic [16:0] rem_sh, rem_sub;
  logic [WW-1:0] weight;
  logic [acnvs_pkg::TotalW-1:0] run_add;
  logic [acnvs_pkg::TotalW-1:0] total_add;

  wire [1:0]  f_cmd = in_tdata[1:0];
  wire [3:0]  f_a   = in_tdata[5:2];
  wire [3:0]  f_b   = in_tdata[9:6];
  wire [15:0] f_dst = in_tdata[25:10];
  wire [15:0] f_phr = in_tdata[41:26];
  wire [6:0]  f_rnd = in_tdata[48:42];

  assign all_mask = 16'((32'd1 << acnvs_pkg::VCount) - 32'd1);
  assign cand = mask_r & all_mask & ~(16'd1 << cur_r);
  assign in_tready = (state_r == S_IDLE);
  assign rd_addr = {cur_r, vtx_r};
  assign wr_ok = (32'(f_a) < acnvs_pkg::VCount) && (32'(f_b) < acnvs_pkg::VCount);
  assign wr_en = (state_r == S_IDLE && in_tready && in_tvalid
                  && f_cmd == acnvs_pkg::CMD_WRITE && wr_ok) || state_r == S_WR2;
  assign wr_addr = (state_r == S_WR2) ? {b_r, vtx_r} : {f_a, f_b};

  assign rem_sh = {rem_r[15:0], quo_r[47]};
  assign rem_sub = rem_sh - {1'b0, dist_r};
  assign weight = quo_r[WW-1:0];
  assign run_add = run_r + acnvs_pkg::TotalW'(weight);
  assign total_add = total_r + acnvs_pkg::TotalW'(weight);
  assign lhs = acnvs_pkg::RunW'(run_add) * acnvs_pkg::RunW'(acnvs_pkg::Percent);
  assign rhs = acnvs_pkg::RunW'(total_r) * acnvs_pkg::RunW'(rnd_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= (state_r == S_WR2) ? acnvs_pkg::edge_t'({pher_r, dist_r})
                                         : acnvs_pkg::edge_t'({f_phr, f_dst});
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mask_r <= '0;
      cur_r <= '0;
      out_tvalid <= 1'b0;
      out_tdata <= '0;
      out_tuser <= 1'b0;
    end else begin
      if (state_r == S_RESULT && (!out_tvalid || out_tready)) begin
        out_tvalid <= 1'b1;
        out_tdata <= {4'd0, pick_r};
        out_tuser <= none_r;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            vtx_r <= (f_cmd == acnvs_pkg::CMD_STEP) ? '0 : f_a;
            b_r <= f_b;
            dist_r <= f_dst;
            pher_r <= f_phr;
            rnd_r <= f_rnd;
            unique case (f_cmd)
              acnvs_pkg::CMD_WRITE: begin
                if (wr_ok) begin
                  state_r <= S_WR2;
                end
              end
              acnvs_pkg::CMD_START: begin
                if (32'(f_a) < acnvs_pkg::VCount) begin
                  cur_r <= f_a;
                  mask_r <= all_mask & ~(16'd1 << f_a);
                end
              end
              acnvs_pkg::CMD_STEP: begin
                pass_r <= 1'b0;
                total_r <= '0;
                run_r <= '0;
                state_r <= S_NEXT;
              end
              default: ;
            endcase
          end
        end
        S_WR2: state_r <= S_IDLE;
        S_NEXT: begin
          if (cand[vtx_r]) begin
            state_r <= S_RD;
          end else if (vtx_r == VW'(acnvs_pkg::VCount - 1)) begin
            if (!pass_r && total_r != '0 && rnd_r < acnvs_pkg::Percent) begin
              pass_r <= 1'b1;
              vtx_r <= '0;
            end else begin
              pick_r <= '0;
              none_r <= 1'b1;
              state_r <= S_RESULT;
            end
          end else begin
            vtx_r <= vtx_r + 1'b1;
          end
        end
        S_RD: begin
          state_r <= S_DIV;
          cnt_r <= '0;
          dist_r <= rd_q.distance;
          quo_r <= {16'd0, rd_q.pheromone, 16'd0};
          rem_r <= '0;
        end
        S_DIV: begin
          if (dist_r == '0) begin
            quo_r <= '0;
            cnt_r <= 6'd48;
          end else if (cnt_r != 6'd48) begin
            cnt_r <= cnt_r + 1'b1;
            if (!rem_sub[16]) begin
              rem_r <= rem_sub;
              quo_r <= {quo_r[46:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[46:0], 1'b0};
            end
          end
          if (cnt_r == 6'd48) begin
            if (!pass_r) begin
              total_r <= total_add;
            end else begin
              run_r <= run_add;
            end
            if (pass_r && lhs > rhs) begin
              pick_r <= vtx_r;
              none_r <= 1'b0;
              cur_r <= vtx_r;
              mask_r <= mask_r & ~(16'd1 << vtx_r);
              state_r <= S_RESULT;
            end else if (vtx_r == VW'(acnvs_pkg::VCount - 1)) begin
              if (!pass_r && total_add != '0 && rnd_r < acnvs_pkg::Percent) begin
                pass_r <= 1'b1;
                vtx_r <= '0;
                state_r <= S_NEXT;
              end else begin
                pick_r <= '0;
                none_r <= 1'b1;
                state_r <= S_RESULT;
              end
            end else begin
              vtx_r <= vtx_r + 1'b1;
              state_r <= S_NEXT;
            end
          end
        end
        S_RESULT: begin
          if (!out_tvalid || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
